// ===== sv/pfsa_pkg.sv =====
// pfsa_pkg: constants and codes shared by the free page stack allocator
// no dependencies; used by page_frame_stack_allocator and pfsa_checker
`default_nettype none

package pfsa_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 65536;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // page geometry
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_NUM_W  = 20;
    localparam int PAGE_CNT_W  = PAGE_NUM_W + 1;
    localparam int ADDR_W      = 32;

    // item field widths
    localparam int FUNC_W      = 2;
    localparam int REGION_W    = 64;
    localparam int IN_BITS     = FUNC_W + ADDR_W + 2 * REGION_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = ADDR_W + 2 + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // request codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_REGION = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

endpackage

`default_nettype wire

// ===== sv/page_frame_stack_allocator.sv =====
// page_frame_stack_allocator: lifo stack of free 4 KiB page numbers
// depends on pfsa_pkg for geometry, widths and request codes
//
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | func, free_addr, region_base, region_length
//  m_*     | out | page_addr, empty_res, overflow, free_count
//
// allocate steps through stack read, data return and result, free through
// accept and result, a region add through accept, a push per page, end check
// and result; the single write port of the stack memory and the shared page
// counter/compare set the region rate.
// the stack memory is not cleared after reset; only entries below the top
// index are ever read. reset empties the stack at once.
// a finished result waits in the output register while the next item is
// taken; a new result is only loaded once the previous one has left.
`default_nettype none

module page_frame_stack_allocator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // func[1:0], free_addr[33:2], region_base[97:34], region_length[161:98]
    input  wire logic [pfsa_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // page_addr[31:0], empty_res[32], overflow[33], free_count[50:34]
    output logic [pfsa_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_REGION,
        ST_FINISH
    } state_t;

    localparam logic [pfsa_pkg::CNT_W-1:0] FULL_CNT = pfsa_pkg::CNT_W'(pfsa_pkg::STACK_DEPTH);

    // stack storage
    logic [pfsa_pkg::PAGE_NUM_W-1:0] stack_mem [pfsa_pkg::STACK_DEPTH];
    logic [pfsa_pkg::PAGE_NUM_W-1:0] rd_data_reg;
    logic                            mem_we;
    logic [pfsa_pkg::IDX_W-1:0]      mem_waddr;
    logic [pfsa_pkg::PAGE_NUM_W-1:0] mem_wdata;
    logic                            mem_re;
    logic [pfsa_pkg::IDX_W-1:0]      mem_raddr;

    // control and working registers
    state_t                          state_reg, state_next;
    logic [pfsa_pkg::CNT_W-1:0]      top_reg, top_next;
    logic [pfsa_pkg::PAGE_CNT_W-1:0] cur_pg_reg, cur_pg_next;
    logic [pfsa_pkg::PAGE_CNT_W-1:0] end_pg_reg, end_pg_next;
    logic [pfsa_pkg::ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                            res_empty_reg, res_empty_next;
    logic                            res_ovf_reg, res_ovf_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pfsa_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // input item fields
    pfsa_pkg::func_t                 in_func;
    logic [pfsa_pkg::ADDR_W-1:0]     in_free_addr;
    logic [pfsa_pkg::REGION_W-1:0]   in_base;
    logic [pfsa_pkg::REGION_W-1:0]   in_len;
    logic                            in_accept;

    // region bounds in page numbers
    logic [pfsa_pkg::ADDR_W:0]       reg_sum;
    logic                            reg_clip;
    logic [pfsa_pkg::PAGE_CNT_W-1:0] reg_first_pg;
    logic [pfsa_pkg::PAGE_CNT_W-1:0] reg_end_pg;
    logic                            stack_full;
    logic                            out_free;

    assign in_func      = pfsa_pkg::func_t'(s_tdata[pfsa_pkg::FUNC_W-1:0]);
    assign in_free_addr = s_tdata[pfsa_pkg::FUNC_W +: pfsa_pkg::ADDR_W];
    assign in_base      = s_tdata[pfsa_pkg::FUNC_W + pfsa_pkg::ADDR_W +: pfsa_pkg::REGION_W];
    assign in_len       = s_tdata[pfsa_pkg::FUNC_W + pfsa_pkg::ADDR_W + pfsa_pkg::REGION_W
                                  +: pfsa_pkg::REGION_W];

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign stack_full = (top_reg == FULL_CNT);
    assign out_free   = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    // round base up, clip end at 4 GiB and round it down
    always_comb
    begin
        reg_sum      = {1'b0, in_base[pfsa_pkg::ADDR_W-1:0]}
                     + {1'b0, in_len[pfsa_pkg::ADDR_W-1:0]};
        reg_clip     = (|in_len[pfsa_pkg::REGION_W-1:pfsa_pkg::ADDR_W])
                    || (reg_sum > {1'b1, {pfsa_pkg::ADDR_W{1'b0}}});
        reg_first_pg = {1'b0, in_base[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT]}
                     + pfsa_pkg::PAGE_CNT_W'(|in_base[pfsa_pkg::PAGE_SHIFT-1:0]);
        if (|in_base[pfsa_pkg::REGION_W-1:pfsa_pkg::ADDR_W])
            reg_end_pg = '0;
        else if (reg_clip)
            reg_end_pg = {1'b1, {pfsa_pkg::PAGE_NUM_W{1'b0}}};
        else
            reg_end_pg = reg_sum[pfsa_pkg::ADDR_W:pfsa_pkg::PAGE_SHIFT];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        cur_pg_next    = cur_pg_reg;
        end_pg_next    = end_pg_reg;
        res_addr_next  = res_addr_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = top_reg[pfsa_pkg::IDX_W-1:0];
        mem_wdata      = in_free_addr[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT];
        mem_re         = 1'b0;
        mem_raddr      = top_reg[pfsa_pkg::IDX_W-1:0] - 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_addr_next  = '0;
                    res_empty_next = 1'b0;
                    res_ovf_next   = 1'b0;
                    state_next     = ST_FINISH;
                    case (in_func)
                        pfsa_pkg::FUNC_ALLOC:
                        begin
                            if (top_reg == '0)
                                res_empty_next = 1'b1;
                            else
                            begin
                                mem_re     = 1'b1;
                                top_next   = top_reg - 1'b1;
                                state_next = ST_POP;
                            end
                        end
                        pfsa_pkg::FUNC_FREE:
                        begin
                            if (stack_full)
                                res_ovf_next = 1'b1;
                            else
                            begin
                                mem_we   = 1'b1;
                                top_next = top_reg + 1'b1;
                            end
                        end
                        pfsa_pkg::FUNC_REGION:
                        begin
                            cur_pg_next = reg_first_pg;
                            end_pg_next = reg_end_pg;
                            state_next  = ST_REGION;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                res_addr_next = {rd_data_reg, {pfsa_pkg::PAGE_SHIFT{1'b0}}};
                state_next    = ST_FINISH;
            end
            ST_REGION:
            begin
                // one page per cycle through the shared counter and compare
                mem_wdata = cur_pg_reg[pfsa_pkg::PAGE_NUM_W-1:0];
                if (cur_pg_reg >= end_pg_reg)
                    state_next = ST_FINISH;
                else if (stack_full)
                begin
                    res_ovf_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    mem_we      = 1'b1;
                    top_next    = top_reg + 1'b1;
                    cur_pg_next = cur_pg_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pfsa_pkg::OUT_TDATA_W'({top_reg, res_ovf_reg,
                                                             res_empty_reg, res_addr_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_pg_reg    <= cur_pg_next;
        end_pg_reg    <= end_pg_next;
        res_addr_reg  <= res_addr_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= stack_mem[mem_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/pfsa_checker.sv =====
// pfsa_port_checks: port level checks on the free page stack allocator results
// depends on pfsa_pkg; bound to page_frame_stack_allocator below
`default_nettype none

module pfsa_port_checks (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [pfsa_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [pfsa_pkg::ADDR_W-1:0] chk_addr;
    logic                        chk_empty;
    logic                        chk_ovf;
    logic [pfsa_pkg::CNT_W-1:0]  chk_count;

    assign chk_addr  = m_tdata[pfsa_pkg::ADDR_W-1:0];
    assign chk_empty = m_tdata[pfsa_pkg::ADDR_W];
    assign chk_ovf   = m_tdata[pfsa_pkg::ADDR_W+1];
    assign chk_count = m_tdata[pfsa_pkg::ADDR_W+2 +: pfsa_pkg::CNT_W];

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty answer means nothing was on the stack and no address given
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && chk_empty |-> chk_count == '0 && chk_addr == '0 && !chk_ovf)
        else $error("empty result inconsistent");

    // addresses are page aligned
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_addr[pfsa_pkg::PAGE_SHIFT-1:0] == '0)
        else $error("page address not aligned");

    // overflow only with a full stack, count never beyond depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_count <= pfsa_pkg::CNT_W'(pfsa_pkg::STACK_DEPTH)
                  && (!chk_ovf || chk_count == pfsa_pkg::CNT_W'(pfsa_pkg::STACK_DEPTH)))
        else $error("free count or overflow out of range");

endmodule

bind page_frame_stack_allocator pfsa_port_checks u_pfsa_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
